// ===== rtl/core/euler_rotate_normalize_core_defines.svh =====
// assertion macros for the euler rotate and normalise core
// needs clk and rst_n in the scope where a macro is used
`ifndef EULER_ROTATE_NORMALIZE_CORE_DEFINES_SVH
`define EULER_ROTATE_NORMALIZE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define EROT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erot check failed");
// next-cycle implication
`define EROT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erot check failed");
`else
`define EROT_ASSERT_NOW(lbl, ante, cons)
`define EROT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/erot_pkg.sv =====
// shared constants, types and arithmetic helpers for the euler rotate core
// no dependencies
package erot_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CSTEPS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int CORDIC_STAGES = (CSTEPS + 1) / 2;

  localparam int VIN_W      = 20;
  localparam int ANG_W      = 18;
  localparam int OUT_W      = 18;
  localparam int GUARD_BITS = 8;
  localparam int ANG_FRAC   = 8;
  localparam int RA_W       = ANG_W + 1;
  localparam int Z_W        = 25;
  localparam int CS_W       = 32;
  localparam int ROT_W      = 30;
  localparam int PROD_W     = ROT_W + CS_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int RND_SHIFT  = 30;
  localparam int SUM_W      = 2 * ROT_W;
  localparam int ISQ_ITERS  = SUM_W / 2;
  localparam int ISQ_STAGES = ISQ_ITERS / 2;
  localparam int ROOT_W     = ISQ_ITERS;
  localparam int QB         = FRAC_BITS + 1;
  localparam int DIV_STAGES = (QB + 1) / 2;
  localparam int NUM_W      = ROOT_W + QB;
  localparam int SAT_W      = QB + OUT_W;

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int PIPE_LAT   = CORDIC_LAT + 5 + ISQ_STAGES + DIV_LAT;

  // angle landmarks in 1/256 degree
  localparam logic signed [RA_W-1:0] ANG_QUARTER = RA_W'(90 * (1 << ANG_FRAC));
  localparam logic signed [RA_W-1:0] ANG_HALF    = RA_W'(180 * (1 << ANG_FRAC));
  localparam logic signed [RA_W-1:0] ANG_FULL    = RA_W'(360 * (1 << ANG_FRAC));

  localparam logic signed [CS_W-1:0]  CORDIC_K = CS_W'(652032874);
  localparam logic signed [SAT_W-1:0] SAT_HI   = SAT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO   = -SAT_W'(1 << (OUT_W - 1));

  typedef struct packed {
    logic signed [VIN_W-1:0] x;
    logic signed [VIN_W-1:0] y;
    logic signed [VIN_W-1:0] z;
  } vin_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic                    zero;
  } rvec_t;

  // atan(2^-i) in degrees, q16
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up then drop the q30 fraction
  function automatic logic signed [ROT_W-1:0] rnd_q30(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] t;
    t = p + (ACC_W'(1) <<< (RND_SHIFT - 1));
    return t[RND_SHIFT+ROT_W-1:RND_SHIFT];
  endfunction

  // a*c - b*s
  function automatic logic signed [ROT_W-1:0] rot_diff(
    input logic signed [ROT_W-1:0] a, input logic signed [ROT_W-1:0] b,
    input logic signed [CS_W-1:0] c, input logic signed [CS_W-1:0] s);
    logic signed [ACC_W-1:0] pa;
    logic signed [ACC_W-1:0] pb;
    pa = a * c;
    pb = b * s;
    return rnd_q30(pa - pb);
  endfunction

  // a*s + b*c
  function automatic logic signed [ROT_W-1:0] rot_sum(
    input logic signed [ROT_W-1:0] a, input logic signed [ROT_W-1:0] b,
    input logic signed [CS_W-1:0] c, input logic signed [CS_W-1:0] s);
    logic signed [ACC_W-1:0] pa;
    logic signed [ACC_W-1:0] pb;
    pa = a * s;
    pb = b * c;
    return rnd_q30(pa + pb);
  endfunction

endpackage

// ===== rtl/core/erot_cordic.sv =====
// pipelined degree cordic: angle in 1/256 degree to cos and sin in q30
// depends on erot_pkg
module erot_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [erot_pkg::ANG_W-1:0] angle,
  output logic signed [erot_pkg::CS_W-1:0]  cos_o,
  output logic signed [erot_pkg::CS_W-1:0]  sin_o
);
  import erot_pkg::*;

  logic signed [RA_W-1:0] ang_ext;
  logic signed [RA_W-1:0] wrap_nxt;
  logic signed [RA_W-1:0] fold_nxt;
  logic                   neg_nxt;

  logic signed [Z_W-1:0]  z_r   [0:CORDIC_STAGES-1];
  logic                   neg_r [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] x_r   [1:CORDIC_STAGES];
  logic signed [CS_W-1:0] y_r   [1:CORDIC_STAGES];
  logic signed [CS_W-1:0] cos_r;
  logic signed [CS_W-1:0] sin_r;

  // wrap into [-180,180) then fold into [-90,90]
  always_comb begin
    ang_ext = RA_W'(angle);
    if (ang_ext >= ANG_HALF) begin
      wrap_nxt = ang_ext - ANG_FULL;
    end else if (ang_ext < -ANG_HALF) begin
      wrap_nxt = ang_ext + ANG_FULL;
    end else begin
      wrap_nxt = ang_ext;
    end
    neg_nxt = 1'b1;
    if (wrap_nxt > ANG_QUARTER) begin
      fold_nxt = wrap_nxt - ANG_HALF;
    end else if (wrap_nxt < -ANG_QUARTER) begin
      fold_nxt = wrap_nxt + ANG_HALF;
    end else begin
      fold_nxt = wrap_nxt;
      neg_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= Z_W'(fold_nxt) <<< ANG_FRAC;
      neg_r[0] <= neg_nxt;
    end
  end

  // two micro-rotations per stage
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CS_W-1:0] xin;
    logic signed [CS_W-1:0] yin;
    logic signed [CS_W-1:0] x_nxt;
    logic signed [CS_W-1:0] y_nxt;
    logic signed [CS_W-1:0] xt;
    logic signed [CS_W-1:0] yt;
    logic signed [Z_W-1:0]  z_nxt;

    if (s == 0) begin : g_first
      assign xin = CORDIC_K;
      assign yin = '0;
    end else begin : g_rest
      assign xin = x_r[s];
      assign yin = y_r[s];
    end

    always_comb begin
      x_nxt = xin;
      y_nxt = yin;
      z_nxt = z_r[s];
      xt    = '0;
      yt    = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < CSTEPS) begin
          xt = x_nxt >>> (2 * s + j);
          yt = y_nxt >>> (2 * s + j);
          if (z_nxt >= 0) begin
            x_nxt = x_nxt - yt;
            y_nxt = y_nxt + xt;
            z_nxt = z_nxt - atan_deg(2 * s + j);
          end else begin
            x_nxt = x_nxt + yt;
            y_nxt = y_nxt - xt;
            z_nxt = z_nxt + atan_deg(2 * s + j);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s+1]   <= x_nxt;
        y_r[s+1]   <= y_nxt;
        neg_r[s+1] <= neg_r[s];
      end
    end

    if (s < CORDIC_STAGES - 1) begin : g_zcarry
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[s+1] <= z_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
      sin_r <= neg_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== rtl/core/erot_div.sv =====
// pipelined rounded divide of one component by the length, with saturation
// depends on erot_pkg
module erot_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [erot_pkg::ROT_W-1:0] comp,
  input  logic        [erot_pkg::ROOT_W-1:0] len,
  input  logic                              zero,
  output logic signed [erot_pkg::OUT_W-1:0] unit
);
  import erot_pkg::*;

  logic        [ROT_W-1:0]  mag_nxt;
  logic        [NUM_W-1:0]  num_nxt;

  logic        [NUM_W-1:0]  rem_r  [0:DIV_STAGES-1];
  logic        [ROOT_W-1:0] len_r  [0:DIV_STAGES-1];
  logic                     neg_r  [0:DIV_STAGES];
  logic                     zero_r [0:DIV_STAGES];
  logic        [QB-1:0]     q_r    [1:DIV_STAGES];

  logic signed [SAT_W-1:0]  val;
  logic signed [OUT_W-1:0]  unit_nxt;
  logic signed [OUT_W-1:0]  unit_r;

  always_comb begin
    mag_nxt = comp[ROT_W-1] ? ROT_W'(-comp) : ROT_W'(comp);
    num_nxt = (NUM_W'(mag_nxt) << FRAC_BITS) + NUM_W'(len >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_nxt;
      len_r[0]  <= len;
      neg_r[0]  <= comp[ROT_W-1];
      zero_r[0] <= zero;
    end
  end

  // restoring division, two quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_nxt;
    logic [NUM_W-1:0] d;
    logic [QB-1:0]    qin;
    logic [QB-1:0]    q_nxt;

    if (s == 0) begin : g_first
      assign qin = '0;
    end else begin : g_rest
      assign qin = q_r[s];
    end

    always_comb begin
      rem_nxt = rem_r[s];
      q_nxt   = qin;
      d       = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < QB) begin
          d = NUM_W'(len_r[s]) << (QB - 1 - (2 * s + j));
          if (rem_nxt >= d) begin
            rem_nxt = rem_nxt - d;
            q_nxt[QB-1-(2*s+j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]    <= q_nxt;
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          len_r[s+1] <= len_r[s];
        end
      end
    end
  end

  always_comb begin
    val = neg_r[DIV_STAGES] ? -SAT_W'(q_r[DIV_STAGES]) : SAT_W'(q_r[DIV_STAGES]);
    if (zero_r[DIV_STAGES]) begin
      unit_nxt = '0;
    end else if (val > SAT_HI) begin
      unit_nxt = OUT_W'(SAT_HI);
    end else if (val < SAT_LO) begin
      unit_nxt = OUT_W'(SAT_LO);
    end else begin
      unit_nxt = OUT_W'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
    end
  end

  assign unit = unit_r;

endmodule

// ===== rtl/core/euler_rotate_normalize_core.sv =====
// Euler rotation and unit-length normalisation of one 3D vector per word.
// Takes a Q3.16 vector and roll, pitch and yaw in 1/256 degree, rotates roll
// about z, then pitch about x, then yaw about y, and returns the Q1.16 unit
// vector, or zeros with zero_length set when the rotated vector is exactly
// zero. Fully pipelined: a new word may enter on every clock while in_stall is
// low, and each word passes in turn through the angle cordics, the three
// rotations, the squares and sum, the square root and the divide. A stall on
// the result side freezes the whole pipeline, so words are held in place and
// input is stalled only while a finished result waits. Depends on erot_pkg,
// erot_cordic, erot_div and the defines header.
`include "euler_rotate_normalize_core_defines.svh"
module euler_rotate_normalize_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [erot_pkg::VIN_W-1:0]  in_vec_x,
  input  logic signed [erot_pkg::VIN_W-1:0]  in_vec_y,
  input  logic signed [erot_pkg::VIN_W-1:0]  in_vec_z,
  input  logic signed [erot_pkg::ANG_W-1:0]  in_pitch_angle,
  input  logic signed [erot_pkg::ANG_W-1:0]  in_yaw_angle,
  input  logic signed [erot_pkg::ANG_W-1:0]  in_roll_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [erot_pkg::OUT_W-1:0]  out_unit_x,
  output logic signed [erot_pkg::OUT_W-1:0]  out_unit_y,
  output logic signed [erot_pkg::OUT_W-1:0]  out_unit_z,
  output logic                               out_zero_length
);
  import erot_pkg::*;

  // global advance: everything moves unless a result is waiting and stalled
  logic pipe_en;

  // valid bit per pipeline stage
  logic [PIPE_LAT-1:0] vld_r;

  // cordic outputs
  logic signed [CS_W-1:0] cp, sp, cy, sy, cr, sr;

  // vector travels beside the cordics
  vin_t vin;
  vin_t vd_r [0:CORDIC_LAT-1];

  // guarded input components, q30 widened
  logic signed [ROT_W-1:0] gx, gy, gz;

  // rotation stages
  logic signed [ROT_W-1:0] r1_x1_r, r1_y1_r, r1_z_r;
  logic signed [CS_W-1:0]  r1_cp_r, r1_sp_r, r1_cy_r, r1_sy_r;
  logic signed [ROT_W-1:0] r2_y2_r, r2_z1_r, r2_x1_r;
  logic signed [CS_W-1:0]  r2_cy_r, r2_sy_r;
  rvec_t                   r3_r;

  // squares and their sum
  logic signed [SUM_W-1:0] px, py, pz;
  logic        [SUM_W-1:0] sqx_r, sqy_r, sqz_r;
  rvec_t                   sq_pay_nxt;
  rvec_t                   sq_pay_r;
  logic        [SUM_W-1:0] sm_r;
  rvec_t                   sm_pay_r;

  // square root stages
  logic  [SUM_W-1:0] isv_r  [0:ISQ_STAGES-1];
  logic  [SUM_W-1:0] isr_r  [0:ISQ_STAGES-1];
  rvec_t             ispay_r [0:ISQ_STAGES-1];

  logic [ROOT_W-1:0] len;
  rvec_t             dv;

  // zero flag runs beside the dividers
  logic zf_r [0:DIV_LAT-1];

  assign pipe_en   = !(out_valid && out_stall);
  assign in_stall  = !pipe_en;
  assign out_valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // sine and cosine of the three angles
  erot_cordic u_cordic_pitch (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_pitch_angle),
    .cos_o (cp),
    .sin_o (sp)
  );

  erot_cordic u_cordic_yaw (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_yaw_angle),
    .cos_o (cy),
    .sin_o (sy)
  );

  erot_cordic u_cordic_roll (
    .clk   (clk),
    .en    (pipe_en),
    .angle (in_roll_angle),
    .cos_o (cr),
    .sin_o (sr)
  );

  assign vin.x = in_vec_x;
  assign vin.y = in_vec_y;
  assign vin.z = in_vec_z;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      vd_r[0] <= vin;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  // eight guard bits below the input lsb
  assign gx = ROT_W'(vd_r[CORDIC_LAT-1].x) <<< GUARD_BITS;
  assign gy = ROT_W'(vd_r[CORDIC_LAT-1].y) <<< GUARD_BITS;
  assign gz = ROT_W'(vd_r[CORDIC_LAT-1].z) <<< GUARD_BITS;

  // roll about z, pitch about x, yaw about y: one plane rotation per stage
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      r1_x1_r <= rot_diff(gx, gy, cr, sr);
      r1_y1_r <= rot_sum(gx, gy, cr, sr);
      r1_z_r  <= gz;
      r1_cp_r <= cp;
      r1_sp_r <= sp;
      r1_cy_r <= cy;
      r1_sy_r <= sy;

      r2_y2_r <= rot_diff(r1_y1_r, r1_z_r, r1_cp_r, r1_sp_r);
      r2_z1_r <= rot_sum(r1_y1_r, r1_z_r, r1_cp_r, r1_sp_r);
      r2_x1_r <= r1_x1_r;
      r2_cy_r <= r1_cy_r;
      r2_sy_r <= r1_sy_r;

      r3_r.z    <= rot_diff(r2_z1_r, r2_x1_r, r2_cy_r, r2_sy_r);
      r3_r.x    <= rot_sum(r2_z1_r, r2_x1_r, r2_cy_r, r2_sy_r);
      r3_r.y    <= r2_y2_r;
      r3_r.zero <= 1'b0;
    end
  end

  // squared length; zero length is simply all components zero
  assign px = r3_r.x * r3_r.x;
  assign py = r3_r.y * r3_r.y;
  assign pz = r3_r.z * r3_r.z;

  always_comb begin
    sq_pay_nxt      = r3_r;
    sq_pay_nxt.zero = (r3_r.x == '0) && (r3_r.y == '0) && (r3_r.z == '0);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sqx_r    <= $unsigned(px);
      sqy_r    <= $unsigned(py);
      sqz_r    <= $unsigned(pz);
      sq_pay_r <= sq_pay_nxt;

      sm_r     <= sqx_r + sqy_r + sqz_r;
      sm_pay_r <= sq_pay_r;
    end
  end

  // digit-by-digit integer square root, two result bits per stage
  for (genvar s = 0; s < ISQ_STAGES; s++) begin : g_isq
    logic  [SUM_W-1:0] vin_s;
    logic  [SUM_W-1:0] rin_s;
    rvec_t             pin_s;
    logic  [SUM_W-1:0] v_nxt;
    logic  [SUM_W-1:0] r_nxt;
    logic  [SUM_W:0]   b;
    logic  [SUM_W:0]   t;

    if (s == 0) begin : g_first
      assign vin_s = sm_r;
      assign rin_s = '0;
      assign pin_s = sm_pay_r;
    end else begin : g_rest
      assign vin_s = isv_r[s-1];
      assign rin_s = isr_r[s-1];
      assign pin_s = ispay_r[s-1];
    end

    always_comb begin
      v_nxt = vin_s;
      r_nxt = rin_s;
      b     = '0;
      t     = '0;
      for (int j = 0; j < 2; j++) begin
        b = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * (2 * s + j));
        t = (SUM_W+1)'(r_nxt) + b;
        if ((SUM_W+1)'(v_nxt) >= t) begin
          v_nxt = v_nxt - SUM_W'(t);
          r_nxt = (r_nxt >> 1) + SUM_W'(b);
        end else begin
          r_nxt = r_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        isv_r[s]   <= v_nxt;
        isr_r[s]   <= r_nxt;
        ispay_r[s] <= pin_s;
      end
    end
  end

  assign len = isr_r[ISQ_STAGES-1][ROOT_W-1:0];
  assign dv  = ispay_r[ISQ_STAGES-1];

  // one divider lane per component
  erot_div u_div_x (
    .clk  (clk),
    .en   (pipe_en),
    .comp (dv.x),
    .len  (len),
    .zero (dv.zero),
    .unit (out_unit_x)
  );

  erot_div u_div_y (
    .clk  (clk),
    .en   (pipe_en),
    .comp (dv.y),
    .len  (len),
    .zero (dv.zero),
    .unit (out_unit_y)
  );

  erot_div u_div_z (
    .clk  (clk),
    .en   (pipe_en),
    .comp (dv.z),
    .len  (len),
    .zero (dv.zero),
    .unit (out_unit_z)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      zf_r[0] <= dv.zero;
      for (int i = 1; i < DIV_LAT; i++) begin
        zf_r[i] <= zf_r[i-1];
      end
    end
  end

  assign out_zero_length = zf_r[DIV_LAT-1];

  // a zero-length word carries all-zero components
  `EROT_ASSERT_NOW(a_zero_gives_zeros, out_valid && out_zero_length,
    (out_unit_x == '0) && (out_unit_y == '0) && (out_unit_z == '0))
  // a normalised vector never has all of its components zero
  `EROT_ASSERT_NOW(a_unit_not_null, out_valid && !out_zero_length,
    (out_unit_x != '0) || (out_unit_y != '0) || (out_unit_z != '0))
  // a stalled result is held, not dropped by the pipeline advance
  `EROT_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
    out_valid && $stable(out_unit_x) && $stable(out_zero_length))

endmodule

// ===== test/euler_rotate_normalize_core_checker.sv =====
// watches both channels of the euler rotate core, predicts each unit vector
// and compares it with what the core returns; depends on erot_pkg
module euler_rotate_normalize_core_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [erot_pkg::VIN_W-1:0] in_vec_x,
  input  logic signed [erot_pkg::VIN_W-1:0] in_vec_y,
  input  logic signed [erot_pkg::VIN_W-1:0] in_vec_z,
  input  logic signed [erot_pkg::ANG_W-1:0] in_pitch_angle,
  input  logic signed [erot_pkg::ANG_W-1:0] in_yaw_angle,
  input  logic signed [erot_pkg::ANG_W-1:0] in_roll_angle,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [erot_pkg::OUT_W-1:0] out_unit_x,
  input  logic signed [erot_pkg::OUT_W-1:0] out_unit_y,
  input  logic signed [erot_pkg::OUT_W-1:0] out_unit_z,
  input  logic                              out_zero_length,
  output int                                fail_count,
  output int                                pending_count,
  output int                                checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import erot_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    zl;
  } unit_vec_t;

  localparam longint DEG90  = 90 * 65536;
  localparam longint DEG180 = 180 * 65536;
  localparam longint DEG360 = 360 * 65536;
  localparam longint GAIN   = 652032874;

  longint atan_q16 [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  unit_vec_t unit_queue[$];

  task automatic sin_cos(input logic signed [ANG_W-1:0] ang, output longint c,
                         output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang) * 256;
    x = GAIN;
    y = 0;
    flip = 0;
    while (z >= DEG180) z -= DEG360;
    while (z < -DEG180) z += DEG360;
    if (z > DEG90) begin
      z -= DEG180;
      flip = 1;
    end else if (z < -DEG90) begin
      z += DEG180;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_q16[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_q16[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint round30(input longint p);
    return (p + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_unit(input longint v,
                                                         input longint unsigned len);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = longint'(((mag << FRAC_BITS) + len / 2) / len);
    if (v < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[OUT_W-1:0];
  endfunction

  task automatic predict_unit(output unit_vec_t r);
    longint x, y, z, cp, sp, cy, sy, cr, sr, x1, y1, y2, z1, z2, x2;
    longint unsigned sum, len;
    x = longint'(in_vec_x) * 256;
    y = longint'(in_vec_y) * 256;
    z = longint'(in_vec_z) * 256;
    sin_cos(in_pitch_angle, cp, sp);
    sin_cos(in_yaw_angle, cy, sy);
    sin_cos(in_roll_angle, cr, sr);
    x1 = round30(x * cr - y * sr);
    y1 = round30(x * sr + y * cr);
    y2 = round30(y1 * cp - z * sp);
    z1 = round30(y1 * sp + z * cp);
    z2 = round30(z1 * cy - x1 * sy);
    x2 = round30(z1 * sy + x1 * cy);
    sum = x2 * x2 + y2 * y2 + z2 * z2;
    if (sum == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
    end else begin
      len = int_sqrt(sum);
      r = '{ux: scale_unit(x2, len), uy: scale_unit(y2, len),
            uz: scale_unit(z2, len), zl: 1'b0};
    end
  endtask

  assign pending_count = unit_queue.size();

  always @(posedge clk) begin
    unit_vec_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
      checked_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_unit(want);
        unit_queue.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{ux: out_unit_x, uy: out_unit_y, uz: out_unit_z, zl: out_zero_length};
        checked_count <= checked_count + 1;
        if (unit_queue.size() == 0) begin
          $display("%0t: result word with nothing expected: %0d %0d %0d zl=%0b",
                   $time, got.ux, got.uy, got.uz, got.zl);
          fail_count <= fail_count + 1;
        end else begin
          want = unit_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %0d %0d %0d zl=%0b actual %0d %0d %0d zl=%0b",
                     $time, want.ux, want.uy, want.uz, want.zl,
                     got.ux, got.uy, got.uz, got.zl);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/euler_rotate_normalize_core_tb.sv =====
// stimulus and verdict for the euler rotate and normalise core
// depends on erot_pkg, the core and euler_rotate_normalize_core_checker
module euler_rotate_normalize_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import erot_pkg::*;

  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ANG_MAX      = 92160;
  localparam int DRAIN_CYCLES = PIPE_LAT + 20;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_zero_length;
  logic signed [VIN_W-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [ANG_W-1:0] in_pitch_angle, in_yaw_angle, in_roll_angle;
  logic signed [OUT_W-1:0] out_unit_x, out_unit_y, out_unit_z;
  int fail_count, pending_count, checked_count;
  int words_sent;
  int cycle_count;
  bit in_busy_stretch, out_busy_stretch;

  euler_rotate_normalize_core dut (.*);

  euler_rotate_normalize_core_checker checker_i (.*);

  // free-running clock, 2 ns period
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung pipeline ends the run here
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, pending_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stall before each word, with stretches of none
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 99) == 0) out_busy_stretch = ~out_busy_stretch;
      n = out_busy_stretch ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // present one word after a random gap and hold it until taken
  task automatic send_word(input logic signed [VIN_W-1:0] vx, vy, vz,
                           input logic signed [ANG_W-1:0] pa, ya, ra);
    int gap;
    if ($urandom_range(0, 99) == 0) in_busy_stretch = ~in_busy_stretch;
    gap = in_busy_stretch ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vec_x       <= vx;
    in_vec_y       <= vy;
    in_vec_z       <= vz;
    in_pitch_angle <= pa;
    in_yaw_angle   <= ya;
    in_roll_angle  <= ra;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    int landmarks [8] = '{0, 90*256, -90*256, 180*256, -180*256, 360*256, -360*256, 45*256};
    case ($urandom_range(0, 3))
      0:       return ANG_W'(landmarks[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1);
      1:       return ANG_W'($urandom_range(0, 2 * 360 * 256) - 360 * 256);
      default: return ANG_W'($urandom_range(0, 2 * ANG_MAX) - ANG_MAX);
    endcase
  endfunction

  function automatic logic signed [VIN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return VIN_W'($urandom_range(0, 8) - 4);
      1:       return $urandom_range(0, 1) ? VIN_W'(524287) : VIN_W'(-524288);
      2:       return VIN_W'($urandom_range(0, 2048) - 1024);
      default: return VIN_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [VIN_W-1:0] vmax, vmin;
    logic signed [ANG_W-1:0] amax, amin, q, h;
    vmax = 524287;
    vmin = -524288;
    amax = ANG_MAX;
    amin = -ANG_MAX;
    q    = 90 * 256;
    h    = 180 * 256;
    words_sent = 0;
    in_busy_stretch = 0;
    out_busy_stretch = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_vec_x, in_vec_y, in_vec_z} = '0;
    {in_pitch_angle, in_yaw_angle, in_roll_angle} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: zero vector, extremes, angle landmarks and wrap-around
    send_word(0, 0, 0, 0, 0, 0);
    send_word(0, 0, 0, amax, amin, q);
    send_word(vmax, vmax, vmax, 0, 0, 0);
    send_word(vmin, vmin, vmin, 0, 0, 0);
    send_word(vmax, vmin, vmax, amax, amax, amax);
    send_word(vmin, vmax, vmin, amin, amin, amin);
    send_word(1, 0, 0, q, 0, 0);
    send_word(0, 1, 0, 0, q, 0);
    send_word(0, 0, 1, 0, 0, q);
    send_word(1, 1, 1, -q, -q, -q);
    send_word(vmax, 0, 0, h, -h, h);
    send_word(0, vmin, 0, -h, h, -h);
    send_word(0, 0, vmax, q + 1, -q - 1, q - 1);
    send_word(-1, -1, -1, 360 * 256, -360 * 256, 0);
    send_word(vmax, 1, -1, 270 * 256, -270 * 256, 45 * 256);
    send_word(12345, -54321, 777, amax, 0, amin);
    send_word(-1, 0, 0, -ANG_W'(1), 1, 0);

    // random words with angles near landmarks and across -360 to +360 degrees
    repeat (RANDOM_WORDS)
      send_word(rand_comp(), rand_comp(), rand_comp(), rand_angle(), rand_angle(),
                rand_angle());
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, compared %0d unit vectors, %0d mismatches",
             words_sent, checked_count, fail_count);
    $display("covered zero vectors, extreme components and angles, wrap and fold cases");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/erot_pkg.sv
rtl/core/erot_cordic.sv
rtl/core/erot_div.sv
rtl/core/euler_rotate_normalize_core.sv
test/euler_rotate_normalize_core_checker.sv
test/euler_rotate_normalize_core_tb.sv
